[hw/rtl/mfa_pkg.sv]
`default_nettype none
package mfa_pkg;

  // Data path width of every operand and result field and of the working registers.
  localparam int WORD_BITS = 64;
  localparam int CNT_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // Request to the shared divide/multiply unit.
  typedef struct packed {
    logic start;
    logic is_mul;
  } unit_req_t;

  // Response from the shared unit.
  typedef struct packed {
    logic done;
    logic ovf;
  } unit_rsp_t;

endpackage
`default_nettype wire

[hw/rtl/mfa_if.sv]
`default_nettype none
interface mfa_in_if import mfa_pkg::*; ();
  logic     valid;
  logic     ready;
  logic [1:0] req_type;
  logic     a_sign;
  word_t    a_whole;
  word_t    a_numer;
  word_t    a_denom;
  logic     b_sign;
  word_t    b_whole;
  word_t    b_numer;
  word_t    b_denom;

  modport source (
    output valid, req_type, a_sign, a_whole, a_numer, a_denom,
           b_sign, b_whole, b_numer, b_denom,
    input  ready
  );
  modport sink (
    input  valid, req_type, a_sign, a_whole, a_numer, a_denom,
           b_sign, b_whole, b_numer, b_denom,
    output ready
  );
endinterface

interface mfa_out_if import mfa_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     r_sign;
  word_t    r_whole;
  word_t    r_numer;
  word_t    r_denom;
  logic [1:0] status;

  modport source (
    output valid, r_sign, r_whole, r_numer, r_denom, status,
    input  ready
  );
  modport sink (
    input  valid, r_sign, r_whole, r_numer, r_denom, status,
    output ready
  );
endinterface
`default_nettype wire

[hw/rtl/mixed_fraction_alu.sv]
`default_nettype none
// Exact arithmetic on signed mixed numbers sign * (whole + numer/denom). An
// item carries an operation (add, subtract, multiply, divide) and two operands;
// the result comes back reduced to lowest terms with numer below denom.
// Status 1 reports a zero denominator or a divide by a zero operand, status 2
// reports that some sum, product or common denominator left 64 bits; in both
// cases the result reads as +0 0/1. A zero result always has a positive sign.
// All division and multiplication goes through one bit-serial unit. An item
// runs through four Euclid GCDs for add and subtract, eleven for multiply and
// twelve for divide, each Euclid step being one division, plus 15, 42 or 46
// further divisions and multiplications; a zero denominator or a zero divisor
// is reported without using the unit. The input ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next item can be taken while it waits.
module mixed_fraction_alu import mfa_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  mfa_in_if.sink    in_ch,
  mfa_out_if.source out_ch
);

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_A0   = 6'd1;
  localparam logic [5:0] S_A1   = 6'd2;
  localparam logic [5:0] S_A2   = 6'd3;
  localparam logic [5:0] S_B0   = 6'd4;
  localparam logic [5:0] S_B1   = 6'd5;
  localparam logic [5:0] S_B2   = 6'd6;
  localparam logic [5:0] S_B3   = 6'd7;
  localparam logic [5:0] S_B4   = 6'd8;
  localparam logic [5:0] S_G0   = 6'd9;
  localparam logic [5:0] S_S0   = 6'd10;
  localparam logic [5:0] S_S1   = 6'd11;
  localparam logic [5:0] S_S2   = 6'd12;
  localparam logic [5:0] S_S3   = 6'd13;
  localparam logic [5:0] S_S4   = 6'd14;
  localparam logic [5:0] S_S5   = 6'd15;
  localparam logic [5:0] S_S6   = 6'd16;
  localparam logic [5:0] S_S7   = 6'd17;
  localparam logic [5:0] S_S8   = 6'd18;
  localparam logic [5:0] S_M0A  = 6'd19;
  localparam logic [5:0] S_M0B  = 6'd20;
  localparam logic [5:0] S_M1   = 6'd21;
  localparam logic [5:0] S_M2   = 6'd22;
  localparam logic [5:0] S_M3   = 6'd23;
  localparam logic [5:0] S_M4   = 6'd24;
  localparam logic [5:0] S_M5   = 6'd25;
  localparam logic [5:0] S_M6   = 6'd26;
  localparam logic [5:0] S_M7   = 6'd27;
  localparam logic [5:0] S_M8   = 6'd28;
  localparam logic [5:0] S_M9   = 6'd29;
  localparam logic [5:0] S_M10  = 6'd30;
  localparam logic [5:0] S_M11  = 6'd31;
  localparam logic [5:0] S_D0   = 6'd32;
  localparam logic [5:0] S_D1   = 6'd33;
  localparam logic [5:0] S_D2   = 6'd34;
  localparam logic [5:0] S_FIN  = 6'd35;

  // Sequencer state. gret is the return point of the Euclid loop, bret the
  // return point of the balancing routine (and of the signed add, which ends
  // by falling into balancing).
  logic [5:0] step;
  logic [5:0] gret;
  logic [5:0] bret;
  logic       launched;

  op_t     op;
  status_t st;
  logic    ovf;
  logic    sa, sb, sx, sy, rs, cflag;

  // Operands, the two addends of the signed add, the working number M,
  // the Euclid pair and scratch.
  word_t aw, an, ad, bw, bn, bd;
  word_t xw, xn, xd, yw, yn, yd;
  word_t mw, mn, md;
  word_t gx, gy, l, t1, t2;

  logic            out_valid;
  logic            o_sign;
  word_t           o_whole, o_numer, o_denom;
  status_t         o_status;

  unit_req_t u_req;
  unit_rsp_t u_rsp;
  word_t     u_x, u_y, u_q, u_r;
  logic      uses_unit;
  logic      u_done;

  logic [WORD_BITS:0] wsum;
  logic               xbig, same;
  logic               out_free;

  mfa_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (u_req),
    .opx (u_x),
    .opy (u_y),
    .rsp (u_rsp),
    .quo (u_q),
    .rem (u_r)
  );

  // Operand selection for the shared unit, by sequencer step.
  always_comb begin
    uses_unit    = 1'b1;
    u_req.is_mul = 1'b0;
    u_x          = gx;
    u_y          = gy;
    case (step)
      S_G0:   begin u_x = gx; u_y = gy; uses_unit = (gy != '0); end
      S_B1:   begin u_x = mn; u_y = gx; end
      S_B2:   begin u_x = md; u_y = gx; end
      S_B3:   begin u_x = mn; u_y = md; end
      S_S1:   begin u_x = xd; u_y = gx; end
      S_S2:   begin u_x = l;  u_y = yd; u_req.is_mul = 1'b1; end
      S_S3:   begin u_x = l;  u_y = xd; end
      S_S4:   begin u_x = xn; u_y = t1; u_req.is_mul = 1'b1; end
      S_S5:   begin u_x = l;  u_y = yd; end
      S_S6:   begin u_x = yn; u_y = t2; u_req.is_mul = 1'b1; end
      S_M0A:  begin u_x = aw; u_y = bw; u_req.is_mul = 1'b1; end
      S_M0B:  begin u_x = aw; u_y = bn; u_req.is_mul = 1'b1; end
      S_M1:   begin u_x = an; u_y = bw; u_req.is_mul = 1'b1; end
      S_M5:   begin u_x = bn; u_y = t1; end
      S_M6:   begin u_x = an; u_y = gx; end
      S_M7:   begin u_x = yn; u_y = yd; u_req.is_mul = 1'b1; end
      S_M8:   begin u_x = ad; u_y = t1; end
      S_M9:   begin u_x = bd; u_y = gx; end
      S_M10:  begin u_x = yn; u_y = yd; u_req.is_mul = 1'b1; end
      S_D0:   begin u_x = bw; u_y = bd; u_req.is_mul = 1'b1; end
      default: uses_unit = 1'b0;
    endcase
    u_req.start = uses_unit && !launched;
  end

  assign u_done = launched && u_rsp.done;

  // The comparison of the scaled numerators for a signed add of unlike signs.
  assign xbig = (xw > yw) || ((xw == yw) && (t1 > t2));
  assign same = (xw == yw) && (t1 == t2);

  always_comb begin
    case (step)
      S_B4:    wsum = {1'b0, mw} + {1'b0, gx};
      S_S7:    wsum = {1'b0, xw} + {1'b0, yw};
      S_S8:    wsum = {1'b0, mw} + {{WORD_BITS{1'b0}}, 1'b1};
      S_D1:    wsum = {1'b0, md} + {1'b0, bn};
      default: wsum = '0;
    endcase
  end

  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (launched) begin
        launched <= !u_rsp.done;
      end else begin
        launched <= u_req.start;
      end
      // The finishing step reloads the output register itself.
      if (out_valid && out_ch.ready && step != S_FIN) begin
        out_valid <= 1'b0;
      end

      case (step)
        S_IDLE: begin
          if (in_ch.valid) begin
            op   <= op_t'(in_ch.req_type);
            sa   <= in_ch.a_sign;
            sb   <= in_ch.b_sign;
            aw   <= in_ch.a_whole;
            an   <= in_ch.a_numer;
            ad   <= in_ch.a_denom;
            bw   <= in_ch.b_whole;
            bn   <= in_ch.b_numer;
            bd   <= in_ch.b_denom;
            ovf  <= 1'b0;
            st   <= ST_OK;
            step <= S_A0;
          end
        end
        S_A0: begin
          if (ad == '0 || bd == '0 || (op == OP_DIV && bw == '0 && bn == '0)) begin
            st   <= ST_DIV0;
            step <= S_FIN;
          end else begin
            mw   <= aw;
            mn   <= an;
            md   <= ad;
            bret <= S_A1;
            step <= S_B0;
          end
        end
        S_A1: begin
          aw   <= mw;
          an   <= mn;
          ad   <= md;
          mw   <= bw;
          mn   <= bn;
          md   <= bd;
          bret <= S_A2;
          step <= S_B0;
        end
        S_A2: begin
          bw <= mw;
          bn <= mn;
          bd <= md;
          case (op)
            OP_MUL: step <= S_M0A;
            OP_DIV: step <= S_D0;
            default: begin
              xw   <= aw;
              xn   <= an;
              xd   <= ad;
              yw   <= mw;
              yn   <= mn;
              yd   <= md;
              sx   <= sa;
              sy   <= sb ^ (op == OP_SUB);
              bret <= S_FIN;
              step <= S_S0;
            end
          endcase
        end

        // Balancing of M: reduce by the GCD, then carry numer/denom into whole.
        S_B0: begin
          md   <= (md == '0) ? word_t'(1) : md;
          gx   <= mn;
          gy   <= (md == '0) ? word_t'(1) : md;
          gret <= S_B1;
          step <= S_G0;
        end
        S_B1: if (u_done) begin mn <= u_q; step <= S_B2; end
        S_B2: if (u_done) begin md <= u_q; step <= S_B3; end
        S_B3: begin
          if (u_done) begin
            gx   <= u_q;
            mn   <= u_r;
            step <= S_B4;
          end
        end
        S_B4: begin
          mw   <= wsum[WORD_BITS-1:0];
          ovf  <= ovf | wsum[WORD_BITS];
          step <= bret;
        end

        // Euclid: one remainder per division until the second value is zero.
        S_G0: begin
          if (gy == '0) begin
            step <= gret;
          end else if (u_done) begin
            gx <= gy;
            gy <= u_r;
          end
        end

        // Signed add of X and Y over the least common denominator.
        S_S0: begin
          gx   <= xd;
          gy   <= yd;
          gret <= S_S1;
          step <= S_G0;
        end
        S_S1: if (u_done) begin l <= u_q; step <= S_S2; end
        S_S2: if (u_done) begin l <= u_r; ovf <= ovf | u_rsp.ovf; step <= S_S3; end
        S_S3: if (u_done) begin t1 <= u_q; step <= S_S4; end
        S_S4: if (u_done) begin t1 <= u_r; ovf <= ovf | u_rsp.ovf; step <= S_S5; end
        S_S5: if (u_done) begin t2 <= u_q; step <= S_S6; end
        S_S6: if (u_done) begin t2 <= u_r; ovf <= ovf | u_rsp.ovf; step <= S_S7; end
        S_S7: begin
          md <= l;
          if (sx == sy) begin
            mw    <= wsum[WORD_BITS-1:0];
            ovf   <= ovf | wsum[WORD_BITS];
            mn    <= t1 + t2;
            cflag <= (t1 >= (l - t2));
            rs    <= sx;
            step  <= S_S8;
          end else if (same) begin
            // Equal magnitudes cancel to a plain zero, left unbalanced.
            mw   <= '0;
            mn   <= '0;
            md   <= word_t'(1);
            rs   <= 1'b0;
            step <= bret;
          end else begin
            mw    <= xbig ? (xw - yw) : (yw - xw);
            mn    <= xbig ? (t1 - t2) : (t2 - t1);
            cflag <= xbig ? (t1 < t2) : (t2 < t1);
            rs    <= xbig ? sx : sy;
            step  <= S_S8;
          end
        end
        S_S8: begin
          if (cflag) begin
            if (sx == sy) begin
              // Fraction sum reached one: carry it into the whole part.
              mn  <= mn - l;
              mw  <= wsum[WORD_BITS-1:0];
              ovf <= ovf | wsum[WORD_BITS];
            end else begin
              // Fraction difference went negative: borrow one from the whole.
              mw <= mw - word_t'(1);
              mn <= mn + l;
            end
          end
          step <= S_B0;
        end

        // Multiply: whole*whole + whole*frac, then + frac*frac.
        S_M0A: begin
          if (u_done) begin
            mw   <= u_r;
            ovf  <= ovf | u_rsp.ovf;
            step <= S_M0B;
          end
        end
        S_M0B: begin
          if (u_done) begin
            mn   <= u_r;
            ovf  <= ovf | u_rsp.ovf;
            md   <= bd;
            bret <= S_M1;
            step <= S_B0;
          end
        end
        S_M1: begin
          if (u_done) begin
            xw   <= mw;
            xn   <= mn;
            xd   <= md;
            mw   <= '0;
            mn   <= u_r;
            md   <= ad;
            ovf  <= ovf | u_rsp.ovf;
            bret <= S_M2;
            step <= S_B0;
          end
        end
        S_M2: begin
          yw   <= mw;
          yn   <= mn;
          yd   <= md;
          sx   <= 1'b0;
          sy   <= 1'b0;
          bret <= S_M3;
          step <= S_S0;
        end
        S_M3: begin
          xw   <= mw;
          xn   <= mn;
          xd   <= md;
          gx   <= bn;
          gy   <= ad;
          gret <= S_M4;
          step <= S_G0;
        end
        S_M4: begin
          t1   <= gx;
          gx   <= an;
          gy   <= bd;
          gret <= S_M5;
          step <= S_G0;
        end
        S_M5: if (u_done) begin yn <= u_q; step <= S_M6; end
        S_M6: if (u_done) begin yd <= u_q; step <= S_M7; end
        S_M7: if (u_done) begin mn <= u_r; ovf <= ovf | u_rsp.ovf; step <= S_M8; end
        S_M8: if (u_done) begin yn <= u_q; step <= S_M9; end
        S_M9: if (u_done) begin yd <= u_q; step <= S_M10; end
        S_M10: begin
          if (u_done) begin
            md   <= u_r;
            mw   <= '0;
            ovf  <= ovf | u_rsp.ovf;
            bret <= S_M11;
            step <= S_B0;
          end
        end
        S_M11: begin
          yw   <= mw;
          yn   <= mn;
          yd   <= md;
          bret <= S_FIN;
          step <= S_S0;
        end

        // Divide: replace b by denom / (whole*denom + numer).
        S_D0: begin
          if (u_done) begin
            md   <= u_r;
            ovf  <= ovf | u_rsp.ovf;
            step <= S_D1;
          end
        end
        S_D1: begin
          md   <= wsum[WORD_BITS-1:0];
          ovf  <= ovf | wsum[WORD_BITS];
          mw   <= '0;
          mn   <= bd;
          bret <= S_D2;
          step <= S_B0;
        end
        S_D2: begin
          bw   <= mw;
          bn   <= mn;
          bd   <= md;
          step <= S_M0A;
        end

        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (st != ST_OK || ovf) begin
              o_status <= (st != ST_OK) ? st : ST_OVF;
              o_sign   <= 1'b0;
              o_whole  <= '0;
              o_numer  <= '0;
              o_denom  <= word_t'(1);
            end else begin
              o_status <= ST_OK;
              o_sign   <= (mw == '0 && mn == '0) ? 1'b0 :
                          ((op == OP_MUL || op == OP_DIV) ? (sa ^ sb) : rs);
              o_whole  <= mw;
              o_numer  <= mn;
              o_denom  <= md;
            end
            step <= S_IDLE;
          end
        end
        default: step <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready    = (step == S_IDLE);
  assign out_ch.valid   = out_valid;
  assign out_ch.r_sign  = o_sign;
  assign out_ch.r_whole = o_whole;
  assign out_ch.r_numer = o_numer;
  assign out_ch.r_denom = o_denom;
  assign out_ch.status  = o_status;

  a_one_launch: assert property (@(posedge clk) disable iff (rst) u_req.start |-> !launched)
    else $error("shared unit started twice");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (step == S_A0))
    else $error("accepted item did not start the sequence");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_OK) |->
    (out_ch.r_whole == '0 && out_ch.r_numer == '0 && out_ch.r_denom == word_t'(1)
     && !out_ch.r_sign))
    else $error("error result is not zero");
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == ST_OK) |-> (out_ch.r_numer < out_ch.r_denom))
    else $error("result numerator not below denominator");

endmodule
`default_nettype wire

[hw/rtl/mfa_arith.sv]
`default_nettype none
// Shared bit-serial unit: restoring division (quotient in quo, remainder in
// rem) or shift-add multiplication (product in rem, overflow flagged).
// One bit per cycle through a single adder.
module mfa_arith import mfa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire unit_req_t req,
  input  wire word_t     opx,
  input  wire word_t     opy,
  output unit_rsp_t      rsp,
  output word_t          quo,
  output word_t          rem
);

  logic             busy;
  logic             is_mul;
  logic             done;
  logic             ovf;
  logic [CNT_W-1:0] cnt;
  word_t            dvs;

  logic [WORD_BITS:0]   add_a;
  logic [WORD_BITS:0]   add_b;
  logic [WORD_BITS+1:0] add_s;

  always_comb begin
    if (is_mul) begin
      add_a = {1'b0, rem[WORD_BITS-2:0], 1'b0};
      add_b = quo[WORD_BITS-1] ? {1'b0, dvs} : '0;
      add_s = {1'b0, add_a} + {1'b0, add_b};
    end else begin
      add_a = {rem, quo[WORD_BITS-1]};
      add_b = ~{1'b0, dvs};
      add_s = {1'b0, add_a} + {1'b0, add_b} + {{(WORD_BITS+1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy   <= 1'b1;
        is_mul <= req.is_mul;
        cnt    <= '0;
        rem    <= '0;
        ovf    <= 1'b0;
        quo    <= req.is_mul ? opy : opx;
        dvs    <= req.is_mul ? opx : opy;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (is_mul) begin
          rem <= add_s[WORD_BITS-1:0];
          quo <= {quo[WORD_BITS-2:0], 1'b0};
          ovf <= ovf | rem[WORD_BITS-1] | add_s[WORD_BITS];
        end else begin
          // Carry out of the subtract means the partial remainder covers the divisor.
          rem <= add_s[WORD_BITS+1] ? add_s[WORD_BITS-1:0] : add_a[WORD_BITS-1:0];
          quo <= {quo[WORD_BITS-2:0], add_s[WORD_BITS+1]};
        end
        if (cnt == CNT_W'(WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("unit done while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req.start && !busy) |=> busy)
    else $error("unit did not start");
  a_div_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (busy && !is_mul) |=> !ovf)
    else $error("overflow raised during division");

endmodule
`default_nettype wire
